>>> rtl/core/gtsf_pkg.sv
// gtsf_pkg: types and constants shared by the split finder modules
// no dependencies
`default_nettype none

package gtsf_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int DEF_SUM_WIDTH = 48;

	localparam int FEAT_W   = 32;
	localparam int GAIN_W   = 64;
	localparam int TOTAL_W  = 48;
	localparam int LAMBDA_W = 31;
	localparam int TERM_W   = 63;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_GRAD = 2'd0,
		REG_TOTAL_HESS = 2'd1,
		REG_L2_LAMBDA  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TERM_LEFT   = 2'd0,
		TERM_RIGHT  = 2'd1,
		TERM_PARENT = 2'd2
	} term_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_MUL,
		ST_DIV,
		ST_STORE,
		ST_JUDGE,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic      load_in;
		logic      load_term;
		logic      mul_step;
		logic      div_step;
		logic      store_term;
		term_sel_t term_sel;
		logic      calc_gain;
		logic      update;
		logic      cmp_best;
		logic      emit;
	} dp_cmd_t;

	typedef struct packed {
		logic boundary;
		logic last;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/gradient_tree_split_finder.sv
// gradient_tree_split_finder: exact greedy split search over a sorted node.
// An item without a feature change goes straight to the sum update; an item
// at a feature change first scores three terms in turn on the shared
// shift-add squarer and restoring divider. The last item adds an emit state
// that loads the result register. One item at a time.
// Reset clears node state, totals to zero and l2_lambda to 1.0.
`default_nettype none

module gradient_tree_split_finder #(
	parameter int FRAC_BITS = gtsf_pkg::DEF_FRAC_BITS,
	parameter int SUM_WIDTH = gtsf_pkg::DEF_SUM_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [gtsf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gtsf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [gtsf_pkg::FEAT_W-1:0] feature_value,
	input  wire logic signed [31:0]                 grad_value,
	input  wire logic signed [31:0]                 hess_value,
	input  wire logic                               last_sample,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [gtsf_pkg::FEAT_W-1:0]      split_threshold,
	output logic signed [gtsf_pkg::GAIN_W-1:0]      split_gain,
	output logic                                    split_found
);
	import gtsf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gtsf_ctrl #(
		.SumWidth(SUM_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gtsf_dp #(
		.FracBits(FRAC_BITS),
		.SumWidth(SUM_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.feature_value   (feature_value),
		.grad_value      (grad_value),
		.hess_value      (hess_value),
		.last_sample     (last_sample),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.split_threshold (split_threshold),
		.split_gain      (split_gain),
		.split_found     (split_found)
	);

endmodule

`default_nettype wire

>>> rtl/core/gtsf_dp.sv
// gtsf_dp: datapath with configuration registers, running sums, shared
// shift-add squarer and restoring divider, best-split tracking, result register
// depends on gtsf_pkg
`default_nettype none

module gtsf_dp #(
	parameter int FracBits = gtsf_pkg::DEF_FRAC_BITS,
	parameter int SumWidth = gtsf_pkg::DEF_SUM_WIDTH
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire gtsf_pkg::dp_cmd_t                     cmd,
	output gtsf_pkg::dp_sts_t                          sts,
	input  wire logic                                  cfg_write,
	input  wire logic [gtsf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [gtsf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic signed [gtsf_pkg::FEAT_W-1:0]    feature_value,
	input  wire logic signed [31:0]                    grad_value,
	input  wire logic signed [31:0]                    hess_value,
	input  wire logic                                  last_sample,
	input  wire logic                                  out_stall,
	output logic                                       out_valid,
	output logic signed [gtsf_pkg::FEAT_W-1:0]         split_threshold,
	output logic signed [gtsf_pkg::GAIN_W-1:0]         split_gain,
	output logic                                       split_found
);
	import gtsf_pkg::*;

	localparam int PW = 2 * SumWidth;

	logic signed [TOTAL_W-1:0]  tot_grad_q, tot_hess_q;
	logic [LAMBDA_W-1:0]        lambda_q;

	logic signed [FEAT_W-1:0]   feat_q;
	logic signed [31:0]         grad_q, hess_q;
	logic                       last_q;

	logic signed [SumWidth-1:0] lsum_g_q, lsum_h_q;
	logic signed [FEAT_W-1:0]   prev_q, first_q, best_thr_q;
	logic signed [GAIN_W-1:0]   best_gain_q, gain_q;
	logic                       seen_q, found_q;

	logic [SumWidth-1:0]        mul_a_q, mul_b_q, dvs_q, rem_q;
	logic [PW-1:0]              prod_q;
	logic                       dzero_q;
	logic [TERM_W-1:0]          tl_q, tp_q;
	logic [GAIN_W-1:0]          sum_q;

	logic                       out_valid_q;
	logic signed [FEAT_W-1:0]   out_thr_q;
	logic signed [GAIN_W-1:0]   out_gain_q;
	logic                       out_found_q;

	logic signed [SumWidth-1:0] gt, ht, op_g, op_h;
	logic signed [SumWidth:0]   hd;
	logic [SumWidth-1:0]        op_abs;
	logic [SumWidth:0]          rem_ext, rem_sub;
	logic                       rem_ge;
	logic [TERM_W-1:0]          term_val;
	logic signed [GAIN_W+1:0]   diff;
	logic signed [FEAT_W:0]     mid_sum;

	assign gt = SumWidth'(tot_grad_q);
	assign ht = SumWidth'(tot_hess_q);

	always_comb begin
		unique case (cmd.term_sel)
			TERM_LEFT: begin
				op_g = lsum_g_q;
				op_h = lsum_h_q;
			end
			TERM_RIGHT: begin
				op_g = gt - lsum_g_q;
				op_h = ht - lsum_h_q;
			end
			default: begin
				op_g = gt;
				op_h = ht;
			end
		endcase
	end

	assign hd = $signed({op_h[SumWidth-1], op_h}) + $signed({(SumWidth-30)'(0), lambda_q});
	assign op_abs = op_g[SumWidth-1] ? (~op_g + SumWidth'(1)) : op_g;

	assign rem_ext = {rem_q, prod_q[PW-1]};
	assign rem_sub = rem_ext - {1'b0, dvs_q};
	assign rem_ge  = (rem_ext >= {1'b0, dvs_q});

	assign term_val = dzero_q ? '0 : ((|prod_q[PW-1:TERM_W]) ? '1 : prod_q[TERM_W-1:0]);

	assign diff = $signed({2'b00, sum_q}) - $signed({3'b000, tp_q});
	assign mid_sum = $signed({prev_q[FEAT_W-1], prev_q}) + $signed({feat_q[FEAT_W-1], feat_q});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_grad_q <= '0;
			tot_hess_q <= '0;
			lambda_q   <= LAMBDA_W'(1) << FracBits;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TOTAL_GRAD: tot_grad_q <= cfg_data[TOTAL_W-1:0];
				REG_TOTAL_HESS: tot_hess_q <= cfg_data[TOTAL_W-1:0];
				REG_L2_LAMBDA:  lambda_q   <= cfg_data[LAMBDA_W-1:0];
				default: ;
			endcase
		end
	end

	// item latch and term unit
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			feat_q <= feature_value;
			grad_q <= grad_value;
			hess_q <= hess_value;
			last_q <= last_sample;
		end
		if (cmd.load_term) begin
			mul_a_q <= op_abs;
			mul_b_q <= op_abs;
			prod_q  <= '0;
			rem_q   <= '0;
			dvs_q   <= hd[SumWidth-1:0];
			dzero_q <= hd[SumWidth] || (hd == '0);
		end else if (cmd.mul_step) begin
			prod_q  <= {prod_q[PW-2:0], 1'b0} +
				(mul_b_q[SumWidth-1] ? {SumWidth'(0), mul_a_q} : PW'(0));
			mul_b_q <= mul_b_q << 1;
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? rem_sub[SumWidth-1:0] : rem_ext[SumWidth-1:0];
			prod_q <= {prod_q[PW-2:0], rem_ge};
		end
		if (cmd.store_term) begin
			unique case (cmd.term_sel)
				TERM_LEFT:  tl_q  <= term_val;
				TERM_RIGHT: sum_q <= {1'b0, tl_q} + {1'b0, term_val};
				default:    tp_q  <= term_val;
			endcase
		end
		if (cmd.calc_gain)
			gain_q <= (!diff[GAIN_W+1] && (diff[GAIN_W] || diff[GAIN_W-1])) ?
				GAIN_MAX : diff[GAIN_W-1:0];
	end

	// node state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_g_q    <= '0;
			lsum_h_q    <= '0;
			prev_q      <= '0;
			first_q     <= '0;
			best_thr_q  <= '0;
			best_gain_q <= '0;
			seen_q      <= 1'b0;
			found_q     <= 1'b0;
		end else if (cmd.emit) begin
			lsum_g_q    <= '0;
			lsum_h_q    <= '0;
			prev_q      <= '0;
			first_q     <= '0;
			best_thr_q  <= '0;
			best_gain_q <= '0;
			seen_q      <= 1'b0;
			found_q     <= 1'b0;
		end else if (cmd.update) begin
			if (cmd.cmp_best && (gain_q > best_gain_q)) begin
				best_gain_q <= gain_q;
				best_thr_q  <= mid_sum[FEAT_W:1];
				found_q     <= 1'b1;
			end
			if (!seen_q)
				first_q <= feat_q;
			seen_q   <= 1'b1;
			prev_q   <= feat_q;
			lsum_g_q <= lsum_g_q + SumWidth'(grad_q);
			lsum_h_q <= lsum_h_q + SumWidth'(hess_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_thr_q   <= found_q ? best_thr_q : first_q;
			out_gain_q  <= found_q ? best_gain_q : '0;
			out_found_q <= found_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign split_threshold = out_thr_q;
	assign split_gain      = out_gain_q;
	assign split_found     = out_found_q;

	assign sts.boundary = seen_q && (feat_q != prev_q);
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid && !seen_q && !found_q)
		else $error("state not cleared after result");

	a_found_gain_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && split_found) |-> (split_gain > 0))
		else $error("split reported with non-positive gain");

	a_best_positive: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_gain_q > 0))
		else $error("best gain kept without being positive");

endmodule

`default_nettype wire

>>> rtl/core/gtsf_ctrl.sv
// gtsf_ctrl: controller state machine sequencing item intake, the three
// score terms, gain judgement, sum update and result hand-off
// depends on gtsf_pkg
`default_nettype none

module gtsf_ctrl #(
	parameter int SumWidth = gtsf_pkg::DEF_SUM_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire gtsf_pkg::dp_sts_t sts,
	output gtsf_pkg::dp_cmd_t      cmd
);
	import gtsf_pkg::*;

	localparam int PW    = 2 * SumWidth;
	localparam int CNT_W = $clog2(PW);

	state_t          state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	term_sel_t       sel_q;
	logic            mul_end, div_end;

	assign mul_end = (cnt_q == CNT_W'(SumWidth - 1));
	assign div_end = (cnt_q == CNT_W'(PW - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_CHECK;
			ST_CHECK:  state_d = sts.boundary ? ST_LOAD : ST_UPDATE;
			ST_LOAD:   state_d = ST_MUL;
			ST_MUL:    if (mul_end) state_d = ST_DIV;
			ST_DIV:    if (div_end) state_d = ST_STORE;
			ST_STORE:  state_d = (sel_q == TERM_PARENT) ? ST_JUDGE : ST_LOAD;
			ST_JUDGE:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = sts.last ? ST_EMIT : ST_IDLE;
			ST_EMIT:   if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.term_sel = sel_q;
		in_stall     = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:   cmd.load_in    = in_valid;
			ST_LOAD:   cmd.load_term  = 1'b1;
			ST_MUL:    cmd.mul_step   = 1'b1;
			ST_DIV:    cmd.div_step   = 1'b1;
			ST_STORE:  cmd.store_term = 1'b1;
			ST_JUDGE:  cmd.calc_gain  = 1'b1;
			ST_UPDATE: begin
				cmd.update   = 1'b1;
				cmd.cmp_best = sts.boundary;
			end
			ST_EMIT:   cmd.emit = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sel_q   <= TERM_LEFT;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK)
				sel_q <= TERM_LEFT;
			else if (state_q == ST_STORE && sel_q == TERM_LEFT)
				sel_q <= TERM_RIGHT;
			else if (state_q == ST_STORE && sel_q == TERM_RIGHT)
				sel_q <= TERM_PARENT;
			if (state_q == ST_LOAD || (state_q == ST_MUL && mul_end))
				cnt_q <= '0;
			else if (state_q == ST_MUL || state_q == ST_DIV)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result issued into a busy output register");

	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mul_end) |=> (state_q == ST_DIV && cnt_q == '0))
		else $error("divider not started after squaring");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> (state_q == ST_CHECK))
		else $error("item taken without moving to check");

endmodule

`default_nettype wire

>>> bench/gtsf_checker.sv
// gtsf_checker: watches the sample and result channels of the split finder,
// predicts each node result and compares it field by field; depends on gtsf_pkg
`timescale 1ns / 1ps

module gtsf_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [47:0]          cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic signed [31:0]   feature_value,
	input  wire logic signed [31:0]   grad_value,
	input  wire logic signed [31:0]   hess_value,
	input  wire logic                 last_sample,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic signed [31:0]   split_threshold,
	input  wire logic signed [63:0]   split_gain,
	input  wire logic                 split_found,
	output int                        fail_count,
	output int                        pending,
	output int                        results_seen,
	output int                        found_seen
);
	import gtsf_pkg::*;

	typedef struct packed {
		logic signed [31:0] thr;
		logic signed [63:0] gain;
		logic               found;
	} split_t;

	localparam logic [63:0] POSMAX = 64'h7FFF_FFFF_FFFF_FFFF;

	split_t node_results[$];

	logic signed [47:0] tot_g, tot_h;
	logic [30:0]        lambda;
	logic signed [47:0] gl, hl;
	logic [31:0]        prev_f, first_f, best_thr;
	logic signed [63:0] best_gain;
	logic               seen, found;

	assign pending = node_results.size();

	function automatic logic [63:0] term_score(logic signed [47:0] g, logic signed [47:0] h,
			logic [30:0] lam);
		logic signed [63:0] d;
		logic [95:0]        sq;
		logic [95:0]        q;
		logic [47:0]        a;
		d = 64'(h) + 64'(lam);
		if (d <= 0) return 64'd0;
		a = g[47] ? 48'(-g) : 48'(g);
		sq = 96'(a) * 96'(a);
		q = sq / 96'(d);
		return (q > 96'(POSMAX)) ? POSMAX : q[63:0];
	endfunction

	task automatic score_edge(input logic [31:0] f);
		logic [63:0]         tl, tr, tp, s, g;
		logic signed [32:0]  m;
		tl = term_score(gl, hl, lambda);
		tr = term_score(tot_g - gl, tot_h - hl, lambda);
		tp = term_score(tot_g, tot_h, lambda);
		s = tl + tr;
		if (s >= tp) begin
			g = s - tp;
			if (g > POSMAX) g = POSMAX;
		end else
			g = -(tp - s);
		if ($signed(g) > best_gain) begin
			m = ($signed({prev_f[31], prev_f}) + $signed({f[31], f})) >>> 1;
			best_gain = g;
			best_thr = m[31:0];
			found = 1'b1;
		end
	endtask

	task automatic clear_node();
		gl = 0; hl = 0; prev_f = 0; first_f = 0; best_thr = 0;
		best_gain = 0; seen = 0; found = 0;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		results_seen = 0;
		found_seen = 0;
		tot_g = 0; tot_h = 0; lambda = 31'd65536;
		clear_node();
	end

	always @(posedge clk) begin
		split_t e;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_TOTAL_GRAD: tot_g = cfg_data;
					REG_TOTAL_HESS: tot_h = cfg_data;
					REG_L2_LAMBDA:  lambda = cfg_data[30:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (node_results.size() == 0) begin
					report("unexpected result", 64'(split_threshold), 64'd0);
				end else begin
					e = node_results.pop_front();
					if (e.found) found_seen++;
					if (split_threshold !== e.thr) report("threshold", 64'(split_threshold), 64'(e.thr));
					if (split_gain !== e.gain) report("gain", split_gain, e.gain);
					if (split_found !== e.found) report("found", 64'(split_found), 64'(e.found));
				end
			end
			if (in_valid && !in_stall) begin
				if (seen && feature_value != prev_f) score_edge(feature_value);
				if (!seen) first_f = feature_value;
				seen = 1;
				prev_f = feature_value;
				gl = gl + 48'(grad_value);
				hl = hl + 48'(hess_value);
				if (last_sample) begin
					e.found = found;
					e.thr = found ? best_thr : first_f;
					e.gain = found ? best_gain : 64'sd0;
					node_results.push_back(e);
					clear_node();
				end
			end
		end
	end
endmodule

>>> bench/gradient_tree_split_finder_tb.sv
// gradient_tree_split_finder_tb: drives register settings and mostly sorted sample nodes
// into the split finder under several idle/stall phases; depends on gtsf_pkg, gtsf_checker
`timescale 1ns / 1ps

module gradient_tree_split_finder_tb;
	import gtsf_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_write = 0;
	logic [1:0]         cfg_index = 0;
	logic [47:0]        cfg_data = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [31:0] feature_value = 0, grad_value = 0, hess_value = 0;
	logic               last_sample = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] split_threshold;
	logic signed [63:0] split_gain;
	logic               split_found;
	int                 fail_count, pending, results_seen, found_seen;
	int                 send_idle_pct = 0, recv_stall_pct = 0;
	int                 samples_sent = 0;

	always #5 clk = ~clk;

	gradient_tree_split_finder DUT (.*);

	gtsf_checker u_checker (.*);

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic send_sample(input logic [31:0] f, input logic [31:0] g, input logic [31:0] h,
			input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; feature_value <= f; grad_value <= g; hess_value <= h;
		last_sample <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (500) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
		cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_small();
		return $signed(32'($urandom_range(0, 2 * 65536 * 8))) - 32'sd524288;
	endfunction

	// one node of n samples; mostly ascending with repeats, sometimes unsorted
	task automatic send_node(input int n, input bit wild);
		logic [31:0] f;
		f = $urandom;
		if (!wild) f = $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
		for (int i = 0; i < n; i++) begin
			if (wild) send_sample($urandom, $urandom, $urandom, i == n - 1);
			else begin
				if ($urandom_range(2) != 0) f = f + $urandom_range(1, 1 << 17);
				send_sample(f, rand_small(), 32'($urandom_range(0, 1 << 18)), i == n - 1);
			end
		end
	endtask

	task automatic set_totals(input logic [47:0] g, input logic [47:0] h, input logic [30:0] l);
		settle();
		write_reg(REG_TOTAL_GRAD, g);
		write_reg(REG_TOTAL_HESS, h);
		write_reg(REG_L2_LAMBDA, {17'd0, l});
		cfg_write <= 0;
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed nodes at reset settings and at several written totals
		send_sample(32'sd5, 32'sd1, 32'sd1, 1'b1);
		send_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		set_totals(48'h0001_0000, 48'h0004_0000, 31'd65536);
		send_sample(32'sd100, 32'sh0003_0000, 32'sh0001_0000, 1'b0);
		send_sample(32'sd100, -32'sh0001_0000, 32'sh0001_0000, 1'b0);
		send_sample(32'sd301, -32'sh0001_0000, 32'sh0001_0000, 1'b0);
		send_sample(32'sd50, 32'sh0000_0000, 32'sh0001_0000, 1'b1);
		set_totals(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 31'h7FFF_FFFF);
		send_sample(-32'sd7, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_sample(-32'sd4, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_sample(32'sd9, 32'sd0, 32'sd0, 1'b1);
		set_totals(48'hFFFF_FFFF_0000, 48'h0000_0000_0000, 31'd0);
		send_sample(32'sd1, 32'sh7FFF_0000, -32'sh0002_0000, 1'b0);
		send_sample(32'sd2, -32'sh7FFF_0000, 32'sh0002_0000, 1'b1);
		// random phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			for (int k = 0; k < 4; k++) begin
				if (k == 3)
					set_totals(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
						31'($urandom));
				else
					set_totals(48'($signed(32'($urandom_range(0, 1 << 22))) - 32'sd2097152),
						48'($urandom_range(0, 1 << 22)), 31'($urandom_range(0, 1 << 18)));
				for (int j = 0; j < 11; j++)
					send_node($urandom_range(1, 14), $urandom_range(9) == 0);
			end
		end
		send_idle_pct = 0;
		settle();
		$display("sent %0d samples, %0d node results checked (%0d with a split)",
			samples_sent, results_seen, found_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#200ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

>>> files.f
rtl/core/gtsf_pkg.sv
rtl/core/gtsf_dp.sv
rtl/core/gtsf_ctrl.sv
rtl/core/gradient_tree_split_finder.sv
bench/gtsf_checker.sv
bench/gradient_tree_split_finder_tb.sv
